>>> rtl/core/rmvg_pkg.sv
package rmvg_pkg;

    localparam int MAX_COPIES  = 256;
    localparam int MAX_PROFILE = 256;
    localparam int COORD_WIDTH = 16;
    localparam int CFG_WIDTH   = 9;

    localparam int CORDIC_STEPS      = 16;
    localparam int CORDIC_WIDTH      = 32;
    localparam int DIV_DEN_WIDTH     = 8;
    localparam int DIV_DVD_WIDTH     = 40;
    localparam int DIV_BITS_PER_CELL = 4;
    localparam int DIV_CELLS         = DIV_DVD_WIDTH / DIV_BITS_PER_CELL;
    localparam int PROD_WIDTH        = COORD_WIDTH + CORDIC_WIDTH + 1;
    localparam int SUM_W             = PROD_WIDTH + 1;
    localparam int RND_W             = SUM_W - 30;

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

    // Configuration register indexes.
    localparam logic CFG_NUM_COPIES  = 1'b0;
    localparam logic CFG_PROFILE_LEN = 1'b1;

    typedef struct packed {
        logic        [7:0]             copy_index;
        logic        [7:0]             point_index;
        logic signed [COORD_WIDTH-1:0] profile_x;
        logic signed [COORD_WIDTH-1:0] profile_y;
        logic signed [COORD_WIDTH-1:0] profile_z;
    } t_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rot_x;
        logic signed [COORD_WIDTH-1:0] rot_y;
        logic signed [COORD_WIDTH-1:0] rot_z;
        logic        [15:0]            vertex_index;
        logic                          quad_valid;
        logic        [15:0]            next_copy_index;
        logic        [15:0]            next_copy_up_index;
        logic        [15:0]            up_index;
    } t_rsp;

    // Data that rides along with a request through the whole pipeline.
    typedef struct packed {
        t_rsp                          rsp;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] pz;
        logic                          no_rot;
        logic        [1:0]             quad;
    } t_side;

    typedef struct packed {
        logic [DIV_DEN_WIDTH-1:0] den;
        logic [DIV_DEN_WIDTH-1:0] rem;
        logic [DIV_DVD_WIDTH-1:0] dvd;
    } t_div;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] x;
        logic signed [CORDIC_WIDTH-1:0] y;
        logic signed [CORDIC_WIDTH-1:0] z;
    } t_cord;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [CORDIC_WIDTH-1:0] rmvg_atan(input logic [3:0] idx);
        logic signed [CORDIC_WIDTH-1:0] a;
        unique case (idx)
            4'd0:    a = 32'sh20000000;
            4'd1:    a = 32'sh12E4051E;
            4'd2:    a = 32'sh09FB385B;
            4'd3:    a = 32'sh051111D4;
            4'd4:    a = 32'sh028B0D43;
            4'd5:    a = 32'sh0145D7E1;
            4'd6:    a = 32'sh00A2F61E;
            4'd7:    a = 32'sh00517C55;
            4'd8:    a = 32'sh0028BE53;
            4'd9:    a = 32'sh00145F2F;
            4'd10:   a = 32'sh000A2F98;
            4'd11:   a = 32'sh000517CC;
            4'd12:   a = 32'sh00028BE6;
            4'd13:   a = 32'sh000145F3;
            4'd14:   a = 32'sh0000A2FA;
            default: a = 32'sh0000517D;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/rmvg_div_cell.sv
module rmvg_div_cell
    import rmvg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_div  i_div,
    input  t_side i_side,
    output logic  o_valid,
    output t_div  o_div,
    output t_side o_side
);

    logic                   r_valid;
    t_div                   r_div;
    t_side                  r_side;
    t_div                   n_div;
    logic [DIV_DEN_WIDTH:0] w_trial;

    // Restoring division, a few quotient bits per cell; quotient bits
    // shift in at the bottom of the dividend register.
    always_comb begin
        n_div   = i_div;
        w_trial = '0;
        for (int k = 0; k < DIV_BITS_PER_CELL; k++) begin
            w_trial = {n_div.rem, n_div.dvd[DIV_DVD_WIDTH-1]};
            if (w_trial >= {1'b0, n_div.den}) begin
                n_div.rem = DIV_DEN_WIDTH'(w_trial - {1'b0, n_div.den});
                n_div.dvd = {n_div.dvd[DIV_DVD_WIDTH-2:0], 1'b1};
            end else begin
                n_div.rem = DIV_DEN_WIDTH'(w_trial);
                n_div.dvd = {n_div.dvd[DIV_DVD_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

>>> rtl/core/rmvg_cordic_cell.sv
module rmvg_cordic_cell
    import rmvg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [3:0] i_stage,
    input  logic       i_valid,
    input  t_cord      i_cord,
    input  t_side      i_side,
    output logic       o_valid,
    output t_cord      o_cord,
    output t_side      o_side
);

    logic                           r_valid;
    t_cord                          r_cord;
    t_side                          r_side;
    t_cord                          n_cord;
    logic signed [CORDIC_WIDTH-1:0] w_dx;
    logic signed [CORDIC_WIDTH-1:0] w_dy;
    logic signed [CORDIC_WIDTH-1:0] w_atan;

    assign w_dx   = i_cord.y >>> i_stage;
    assign w_dy   = i_cord.x >>> i_stage;
    assign w_atan = rmvg_atan(i_stage);

    always_comb begin
        if (i_cord.z >= 0) begin
            n_cord.x = i_cord.x - w_dx;
            n_cord.y = i_cord.y + w_dy;
            n_cord.z = i_cord.z - w_atan;
        end else begin
            n_cord.x = i_cord.x + w_dx;
            n_cord.y = i_cord.y - w_dy;
            n_cord.z = i_cord.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_cord  = r_cord;
    assign o_side  = r_side;

endmodule

>>> rtl/core/revolution_mesh_vertex_gen_top.sv
// Surface-of-revolution vertex generator. Each request carries one profile
// point with its copy and point index; the block rotates it about the Y axis
// by 2*pi*copy/(num_copies-1) and returns the rotated point, its linear
// vertex index and the corner indices of the quad that starts there. It is a
// fully pipelined chain: one request per cycle while not stalled, through the
// input stage, 10 cells of a 4-bit-per-cell restoring divider that forms
// the angle, 16 CORDIC cells, product stage and output register; rounding
// and saturation sit in front of the output register. A stall on the result
// side while a result is held freezes the whole chain. Configuration must be
// written only while no request is in flight; the block does not enforce it.
module revolution_mesh_vertex_gen_top
    import rmvg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output t_rsp                 o_rsp
);

    logic [CFG_WIDTH-1:0] r_num_copies;
    logic [CFG_WIDTH-1:0] r_profile_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_copies  <= CFG_WIDTH'(2);
            r_profile_len <= CFG_WIDTH'(2);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NUM_COPIES:  r_num_copies  <= i_cfg_data;
                CFG_PROFILE_LEN: r_profile_len <= i_cfg_data;
                default:         r_num_copies  <= r_num_copies;
            endcase
        end
    end

    logic r_out_valid;
    logic w_en;

    assign w_en        = !r_out_valid || !i_rsp_stall;
    assign o_req_stall = !w_en;

    // Input stage: clamp the configuration and work out the indices.
    logic [CFG_WIDTH-1:0] w_copies;
    logic [CFG_WIDTH-1:0] w_len;
    logic [16:0]          w_vidx;
    logic [15:0]          w_v;
    t_side                n_side0;
    t_div                 n_div0;

    assign w_copies = (r_num_copies > CFG_WIDTH'(MAX_COPIES)) ?
                      CFG_WIDTH'(MAX_COPIES) : r_num_copies;
    assign w_len    = (r_profile_len > CFG_WIDTH'(MAX_PROFILE)) ?
                      CFG_WIDTH'(MAX_PROFILE) : r_profile_len;
    assign w_vidx   = 17'(i_req.copy_index) * 17'(w_len) + 17'(i_req.point_index);
    assign w_v      = w_vidx[15:0];

    always_comb begin
        n_side0                        = '0;
        n_side0.rsp.rot_y              = i_req.profile_y;
        n_side0.rsp.vertex_index       = w_v;
        n_side0.rsp.quad_valid         =
            ({1'b0, i_req.copy_index} + CFG_WIDTH'(1) < w_copies) &&
            ({1'b0, i_req.point_index} + CFG_WIDTH'(1) < w_len);
        n_side0.rsp.next_copy_index    = w_v + 16'(w_len);
        n_side0.rsp.next_copy_up_index = w_v + 16'(w_len) + 16'd1;
        n_side0.rsp.up_index           = w_v + 16'd1;
        n_side0.px                     = i_req.profile_x;
        n_side0.pz                     = i_req.profile_z;
        n_side0.no_rot                 = w_copies < CFG_WIDTH'(2);
        n_div0.den                     = DIV_DEN_WIDTH'(w_copies - CFG_WIDTH'(1));
        n_div0.rem                     = '0;
        n_div0.dvd                     = {i_req.copy_index, 32'd0};
    end

    logic  r_s0_valid;
    t_side r_s0_side;
    t_div  r_s0_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side <= n_side0;
            r_s0_div  <= n_div0;
        end
    end

    // Divider chain: phase = floor(copy * 2^32 / (copies - 1)) mod 2^32.
    logic  w_dv_valid [DIV_CELLS+1];
    t_div  w_dv_div   [DIV_CELLS+1];
    t_side w_dv_side  [DIV_CELLS+1];

    assign w_dv_valid[0] = r_s0_valid;
    assign w_dv_div[0]   = r_s0_div;
    assign w_dv_side[0]  = r_s0_side;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        rmvg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_valid[g]),
            .i_div   (w_dv_div[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_valid[g+1]),
            .o_div   (w_dv_div[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // CORDIC chain.
    logic        [31:0] w_phase;
    logic               w_cd_valid [CORDIC_STEPS+1];
    t_cord              w_cd_cord  [CORDIC_STEPS+1];
    t_side              w_cd_side  [CORDIC_STEPS+1];

    assign w_phase = w_dv_side[DIV_CELLS].no_rot ? 32'd0 : w_dv_div[DIV_CELLS].dvd[31:0];

    always_comb begin
        w_cd_side[0]      = w_dv_side[DIV_CELLS];
        w_cd_side[0].quad = w_phase[31:30];
        w_cd_cord[0].x    = CORDIC_GAIN;
        w_cd_cord[0].y    = '0;
        w_cd_cord[0].z    = {2'b00, w_phase[29:0]};
    end

    assign w_cd_valid[0] = w_dv_valid[DIV_CELLS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        rmvg_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (4'(g)),
            .i_valid (w_cd_valid[g]),
            .i_cord  (w_cd_cord[g]),
            .i_side  (w_cd_side[g]),
            .o_valid (w_cd_valid[g+1]),
            .o_cord  (w_cd_cord[g+1]),
            .o_side  (w_cd_side[g+1])
        );
    end

    // Quadrant turn and products.
    t_cord                         w_cf;
    t_side                         w_cs;
    logic signed [CORDIC_WIDTH:0]  w_cos;
    logic signed [CORDIC_WIDTH:0]  w_sin;
    logic signed [CORDIC_WIDTH:0]  w_xe;
    logic signed [CORDIC_WIDTH:0]  w_ye;

    assign w_cf = w_cd_cord[CORDIC_STEPS];
    assign w_cs = w_cd_side[CORDIC_STEPS];
    assign w_xe = (CORDIC_WIDTH+1)'(w_cf.x);
    assign w_ye = (CORDIC_WIDTH+1)'(w_cf.y);

    always_comb begin
        unique case (w_cs.quad)
            2'd0:    begin w_cos = w_xe;  w_sin = w_ye;  end
            2'd1:    begin w_cos = -w_ye; w_sin = w_xe;  end
            2'd2:    begin w_cos = -w_xe; w_sin = -w_ye; end
            default: begin w_cos = w_ye;  w_sin = -w_xe; end
        endcase
    end

    logic                         r_m_valid;
    t_side                        r_m_side;
    logic signed [PROD_WIDTH-1:0] r_pxc;
    logic signed [PROD_WIDTH-1:0] r_pzs;
    logic signed [PROD_WIDTH-1:0] r_pzc;
    logic signed [PROD_WIDTH-1:0] r_pxs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_cd_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_side <= w_cs;
            r_pxc    <= PROD_WIDTH'(w_cs.px) * PROD_WIDTH'(w_cos);
            r_pzs    <= PROD_WIDTH'(w_cs.pz) * PROD_WIDTH'(w_sin);
            r_pzc    <= PROD_WIDTH'(w_cs.pz) * PROD_WIDTH'(w_cos);
            r_pxs    <= PROD_WIDTH'(w_cs.px) * PROD_WIDTH'(w_sin);
        end
    end

    // Round to Q4.12 and saturate.
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_z;
    logic signed [RND_W-1:0] w_rnd_x;
    logic signed [RND_W-1:0] w_rnd_z;
    logic signed [RND_W-1:0] w_max;
    logic signed [RND_W-1:0] w_min;
    t_rsp                    n_rsp;

    assign w_sum_x = SUM_W'(r_pxc) + SUM_W'(r_pzs) + SUM_W'(64'sd536870912);
    assign w_sum_z = SUM_W'(r_pzc) - SUM_W'(r_pxs) + SUM_W'(64'sd536870912);
    assign w_rnd_x = $signed(w_sum_x[SUM_W-1:30]);
    assign w_rnd_z = $signed(w_sum_z[SUM_W-1:30]);
    assign w_max   = RND_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    assign w_min   = -w_max - RND_W'(1);

    always_comb begin
        n_rsp = r_m_side.rsp;
        if (w_rnd_x > w_max) begin
            n_rsp.rot_x = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (w_rnd_x < w_min) begin
            n_rsp.rot_x = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_rsp.rot_x = COORD_WIDTH'(w_rnd_x);
        end
        if (w_rnd_z > w_max) begin
            n_rsp.rot_z = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (w_rnd_z < w_min) begin
            n_rsp.rot_z = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_rsp.rot_z = COORD_WIDTH'(w_rnd_z);
        end
    end

    t_rsp r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
